/* src/specular_direction_unit_assert.svh */
// Assertion macros for the specular direction unit checker.
// Depends on signals named clock and reset in the scope of use.
`ifndef SPECULAR_DIRECTION_UNIT_ASSERT_SVH
`define SPECULAR_DIRECTION_UNIT_ASSERT_SVH

// Check a property while out of reset.
`define SDU_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SDU_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/sdu_pkg.sv */
// Shared widths, constants, rounding and saturation helpers for the specular direction unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdu_pkg;

   localparam int COMP_WIDTH = 16;
   localparam int FRAC       = COMP_WIDTH - 2;

   // product widths
   localparam int RW  = 2 * COMP_WIDTH + 8;
   localparam int PNW = 2 * COMP_WIDTH;
   localparam int PEW = 2 * COMP_WIDTH + 1;
   localparam int PE2 = 2 * COMP_WIDTH;
   localparam int P2D = 2 * COMP_WIDTH + 4;
   localparam int PDD = 2 * COMP_WIDTH + 6;
   localparam int PED = 2 * COMP_WIDTH + 4;
   localparam int PST = 2 * COMP_WIDTH + 2;
   localparam int PKN = 2 * COMP_WIDTH + 7;

   // rounded value widths
   localparam int DW   = COMP_WIDTH + 3;
   localparam int E2W  = COMP_WIDTH + 3;
   localparam int EWW  = COMP_WIDTH + 3;
   localparam int RFW  = COMP_WIDTH + 7;
   localparam int EDW  = COMP_WIDTH + 6;
   localparam int S2IW = FRAC + 1;
   localparam int SQW  = 2 * FRAC + 2;
   localparam int RTW  = FRAC + 1;
   localparam int KW   = COMP_WIDTH + 7;
   localparam int OW   = COMP_WIDTH + 10;

   // square root pipeline split
   localparam int SQ_ST  = 3;
   localparam int SQ_PER = (FRAC + SQ_ST) / SQ_ST;

   localparam logic signed [RW-1:0] ONE_R  = RW'(64'sd1 <<< FRAC);
   localparam logic signed [RW-1:0] HALF_R = RW'(64'sd1 <<< (FRAC - 1));
   localparam logic signed [OW-1:0] SAT_HI = OW'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
   localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

   typedef logic signed [COMP_WIDTH-1:0] comp_type;

   // payload that rides along the back half of the pipe
   typedef struct {
      logic                    mode;
      logic                    tir;
      comp_type                n   [3];
      logic signed [EWW-1:0]   ew  [3];
      logic signed [RFW-1:0]   refl[3];
      logic signed [EDW-1:0]   ed;
   } carry_type;

   // divide by 2^FRAC, round to nearest, ties away from zero
   function automatic logic signed [RW-1:0] rnd_q(input logic signed [RW-1:0] p);
      logic signed [RW-1:0] bias;
      bias = p[RW-1] ? (HALF_R - RW'(1)) : HALF_R;
      return (p + bias) >>> FRAC;
   endfunction

   function automatic comp_type sat_q(input logic signed [OW-1:0] v);
      logic signed [OW-1:0] c;
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return c[COMP_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* src/specular_direction_unit.sv */
// Top level of the specular direction unit: reflection and refraction pipeline.
// Depends on sdu_pkg.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_ready  mode, incident, normal, index ratio
//   rsp_      out         rsp_valid / rsp_ready  result direction, total_internal
//
// Twelve register stages; one transaction enters per cycle while the output is not stalled.
// The depth is set by the chained multiplies and the 15-step square root split over
// three stages. Reset clears the valid bits only. When the output stage holds a result
// that is not taken, the whole pipe holds; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module specular_direction_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_mode,
   input  wire logic signed [sdu_pkg::COMP_WIDTH-1:0] req_in_x,
   input  wire logic signed [sdu_pkg::COMP_WIDTH-1:0] req_in_y,
   input  wire logic signed [sdu_pkg::COMP_WIDTH-1:0] req_in_z,
   input  wire logic signed [sdu_pkg::COMP_WIDTH-1:0] req_norm_x,
   input  wire logic signed [sdu_pkg::COMP_WIDTH-1:0] req_norm_y,
   input  wire logic signed [sdu_pkg::COMP_WIDTH-1:0] req_norm_z,
   input  wire logic        [sdu_pkg::COMP_WIDTH-1:0] req_index_ratio,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic signed [sdu_pkg::COMP_WIDTH-1:0] rsp_out_x,
   output      logic signed [sdu_pkg::COMP_WIDTH-1:0] rsp_out_y,
   output      logic signed [sdu_pkg::COMP_WIDTH-1:0] rsp_out_z,
   output      logic                              rsp_total_internal
);
   import sdu_pkg::*;

   localparam int W = COMP_WIDTH;

   logic          advance;
   logic [12:1]   v_ff;

   // stage 1: raw products
   logic                   s1_mode_ff;
   comp_type               s1_w_ff [3], s1_n_ff [3], w_in [3], n_in [3];
   logic [W-1:0]           s1_eta_ff;
   logic signed [PNW-1:0]  s1_pnw_ff [3], s1_pnw_in [3];
   logic signed [PEW-1:0]  s1_pew_ff [3], s1_pew_in [3];
   logic [PE2-1:0]         s1_pe2_ff, s1_pe2_in;

   // stage 2: dot product, eta squared, eta times incident
   logic                   s2_mode_ff;
   comp_type               s2_w_ff [3], s2_n_ff [3];
   logic [W-1:0]           s2_eta_ff;
   logic signed [DW-1:0]   s2_d_ff, s2_d_in;
   logic [E2W-1:0]         s2_e2_ff, s2_e2_in;
   logic signed [EWW-1:0]  s2_ew_ff [3], s2_ew_in [3];

   // stage 3: second round of products
   logic                   s3_mode_ff;
   comp_type               s3_w_ff [3], s3_n_ff [3];
   logic [E2W-1:0]         s3_e2_ff;
   logic signed [EWW-1:0]  s3_ew_ff [3];
   logic signed [P2D-1:0]  s3_p2d_ff [3], s3_p2d_in [3];
   logic signed [PDD-1:0]  s3_pdd_ff, s3_pdd_in;
   logic signed [PED-1:0]  s3_ped_ff, s3_ped_in;

   // stage 4: reflection result, sin2I, eta*cosI
   carry_type              cr_ff [4:11];
   carry_type              cr4_in;
   logic [E2W-1:0]         s4_e2_ff;
   logic [S2IW-1:0]        s4_sin2i_ff, s4_sin2i_in;

   // stage 5: eta^2 * sin2I
   logic [PST-1:0]         s5_pst_ff, s5_pst_in;

   // stage 6 .. 9: TIR test and square root
   logic                   tir_in;
   carry_type              cr6_in;
   logic [SQW-1:0]         sq_rem_ff  [0:SQ_ST-1];
   logic [SQW-1:0]         sq_rem_in  [0:SQ_ST-1];
   logic [RTW-1:0]         sq_root_ff [0:SQ_ST];
   logic [RTW-1:0]         sq_root_in [1:SQ_ST];

   // stage 10 .. 12
   logic signed [KW-1:0]   s10_k_ff, s10_k_in;
   logic signed [PKN-1:0]  s11_pkn_ff [3], s11_pkn_in [3];
   comp_type               out_ff [3], out_in [3];
   logic                   tir_out_ff;

   // hold everything while a finished result waits
   assign advance   = !v_ff[12] || rsp_ready;
   assign req_ready = advance;

   assign w_in[0] = req_in_x;
   assign w_in[1] = req_in_y;
   assign w_in[2] = req_in_z;
   assign n_in[0] = req_norm_x;
   assign n_in[1] = req_norm_y;
   assign n_in[2] = req_norm_z;

   // stage 1 products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_pnw_in[i] = PNW'(n_in[i]) * PNW'(w_in[i]);
         s1_pew_in[i] = PEW'(signed'({1'b0, req_index_ratio})) * PEW'(w_in[i]);
      end
      s1_pe2_in = PE2'(req_index_ratio) * PE2'(req_index_ratio);
   end

   // stage 2 rounding and sum
   always_comb begin
      s2_d_in = DW'(rnd_q(RW'(s1_pnw_ff[0]))) + DW'(rnd_q(RW'(s1_pnw_ff[1])))
              + DW'(rnd_q(RW'(s1_pnw_ff[2])));
      s2_e2_in = E2W'(rnd_q(RW'(s1_pe2_ff)));
      for (int i = 0; i < 3; i++)
         s2_ew_in[i] = EWW'(rnd_q(RW'(s1_pew_ff[i])));
   end

   // stage 3 products
   always_comb begin
      for (int i = 0; i < 3; i++)
         s3_p2d_in[i] = (P2D'(s2_d_ff) <<< 1) * P2D'(s2_n_ff[i]);
      s3_pdd_in = PDD'(s2_d_ff) * PDD'(s2_d_ff);
      s3_ped_in = PED'(signed'({1'b0, s2_eta_ff})) * PED'(s2_d_ff);
   end

   // stage 4: reflection done here; clamp sin2I at zero
   always_comb begin
      logic signed [RW-1:0] s2i;
      s2i = ONE_R - rnd_q(RW'(s3_pdd_ff));
      s4_sin2i_in = s2i[RW-1] ? '0 : S2IW'(s2i);
      cr4_in.mode = s3_mode_ff;
      cr4_in.tir  = 1'b0;
      cr4_in.ed   = EDW'(rnd_q(RW'(s3_ped_ff)));
      for (int i = 0; i < 3; i++) begin
         cr4_in.n[i]    = s3_n_ff[i];
         cr4_in.ew[i]   = s3_ew_ff[i];
         cr4_in.refl[i] = RFW'(rnd_q(RW'(s3_p2d_ff[i]))) - RFW'(s3_w_ff[i]);
      end
   end

   assign s5_pst_in = PST'(s4_e2_ff) * PST'(s4_sin2i_ff);

   // stage 6: sin2T, TIR flag, radicand (1 - sin2T) << FRAC
   always_comb begin
      logic signed [RW-1:0] st, diff;
      logic                 over;
      st     = rnd_q(RW'(s5_pst_ff));
      over   = st >= ONE_R;
      tir_in = cr_ff[5].mode && over;
      cr6_in     = cr_ff[5];
      cr6_in.tir = tir_in;
      diff   = ONE_R - st;
      sq_rem_in[0] = over ? '0 : (SQW'(diff[RTW-1:0]) << FRAC);
   end

   // stages 7 .. 9: restoring square root, SQ_PER result bits each
   for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
      logic [SQW-1:0] rem_nx;
      always_comb begin
         logic [SQW-1:0] rem, trial;
         logic [RTW-1:0] root;
         int             bp;
         rem  = sq_rem_ff[g];
         root = sq_root_ff[g];
         for (int j = 0; j < SQ_PER; j++) begin
            bp = FRAC - g * SQ_PER - j;
            if (bp >= 0) begin
               trial = (SQW'(root) << (bp + 1)) + (SQW'(1) << (2 * bp));
               if (rem >= trial) begin
                  rem  = rem - trial;
                  root = root | (RTW'(1) << bp);
               end
            end
         end
         rem_nx            = rem;
         sq_root_in[g + 1] = root;
      end
      if (g < SQ_ST - 1) begin : g_keep
         assign sq_rem_in[g + 1] = rem_nx;
      end
   end

   // stage 10 .. 12
   assign s10_k_in = KW'(cr_ff[9].ed) - KW'(signed'({1'b0, sq_root_ff[SQ_ST]}));

   always_comb begin
      logic signed [OW-1:0] rr;
      for (int i = 0; i < 3; i++) begin
         s11_pkn_in[i] = PKN'(s10_k_ff) * PKN'(cr_ff[10].n[i]);
         rr = OW'(rnd_q(RW'(s11_pkn_ff[i]))) - OW'(cr_ff[11].ew[i]);
         if (cr_ff[11].tir)
            out_in[i] = '0;
         else if (cr_ff[11].mode)
            out_in[i] = sat_q(rr);
         else
            out_in[i] = sat_q(OW'(cr_ff[11].refl[i]));
      end
   end

   // valid bits: reset clears them, advance shifts them
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[11:1], req_valid};
      end
   end

   // payload: no reset, hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff <= req_mode;
         s1_eta_ff  <= req_index_ratio;
         s1_pe2_ff  <= s1_pe2_in;
         s2_mode_ff <= s1_mode_ff;
         s2_eta_ff  <= s1_eta_ff;
         s2_d_ff    <= s2_d_in;
         s2_e2_ff   <= s2_e2_in;
         s3_mode_ff <= s2_mode_ff;
         s3_e2_ff   <= s2_e2_ff;
         s3_pdd_ff  <= s3_pdd_in;
         s3_ped_ff  <= s3_ped_in;
         for (int i = 0; i < 3; i++) begin
            s1_w_ff[i]    <= w_in[i];
            s1_n_ff[i]    <= n_in[i];
            s1_pnw_ff[i]  <= s1_pnw_in[i];
            s1_pew_ff[i]  <= s1_pew_in[i];
            s2_w_ff[i]    <= s1_w_ff[i];
            s2_n_ff[i]    <= s1_n_ff[i];
            s2_ew_ff[i]   <= s2_ew_in[i];
            s3_w_ff[i]    <= s2_w_ff[i];
            s3_n_ff[i]    <= s2_n_ff[i];
            s3_ew_ff[i]   <= s2_ew_ff[i];
            s3_p2d_ff[i]  <= s3_p2d_in[i];
            s11_pkn_ff[i] <= s11_pkn_in[i];
            out_ff[i]     <= out_in[i];
         end
         cr_ff[4]    <= cr4_in;
         cr_ff[5]    <= cr_ff[4];
         cr_ff[6]    <= cr6_in;
         for (int k = 7; k <= 11; k++)
            cr_ff[k] <= cr_ff[k - 1];
         s4_e2_ff    <= s3_e2_ff;
         s4_sin2i_ff <= s4_sin2i_in;
         s5_pst_ff   <= s5_pst_in;
         sq_root_ff[0] <= '0;
         for (int k = 0; k < SQ_ST; k++)
            sq_rem_ff[k] <= sq_rem_in[k];
         for (int k = 1; k <= SQ_ST; k++)
            sq_root_ff[k] <= sq_root_in[k];
         s10_k_ff   <= s10_k_in;
         tir_out_ff <= cr_ff[11].tir;
      end
   end

   assign rsp_valid          = v_ff[12];
   assign rsp_out_x          = out_ff[0];
   assign rsp_out_y          = out_ff[1];
   assign rsp_out_z          = out_ff[2];
   assign rsp_total_internal = tir_out_ff;

endmodule

`default_nettype wire

/* src/sdu_checker.sv */
// Port-level checker for the specular direction unit, bound to the top level.
// Depends on sdu_pkg and specular_direction_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "specular_direction_unit_assert.svh"

module sdu_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_ready,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [sdu_pkg::COMP_WIDTH-1:0] rsp_out_x,
   input wire logic signed [sdu_pkg::COMP_WIDTH-1:0] rsp_out_y,
   input wire logic signed [sdu_pkg::COMP_WIDTH-1:0] rsp_out_z,
   input wire logic                                  rsp_total_internal
);
   // hold a stalled transaction
   `SDU_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_total_internal), "stalled result changed")
   // total internal reflection gives a zero vector
   `SDU_ASSERT_RUN(a_tir_zero, rsp_valid && rsp_total_internal |-> rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0, "TIR result not zero")
   // an empty output stage never blocks input
   `SDU_ASSERT_RUN(a_ready_free, !rsp_valid |-> req_ready, "input blocked with empty output")
   // reset empties the pipe
   `SDU_ASSERT_ALL(a_reset_empty, $past(reset) |-> !rsp_valid && req_ready, "pipe not empty after reset")
endmodule

bind specular_direction_unit sdu_checker u_sdu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_x          (rsp_out_x),
   .rsp_out_y          (rsp_out_y),
   .rsp_out_z          (rsp_out_z),
   .rsp_total_internal (rsp_total_internal)
);

`default_nettype wire
